// File: hdl/huffman_tree_walk_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define HTWD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define HTWD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/htwd_pkg.sv
`timescale 1ns / 1ps

package htwd_pkg;

   localparam int SYM_W     = 8;
   localparam int BYTE_BITS = 8;
   localparam int CNT_W     = 4;

   // operation codes on req_tuser
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_HEADER = 2'd1;
   localparam logic [1:0] OP_DATA   = 2'd2;

   // preorder header: this byte announces a leaf, its symbol follows
   localparam logic [SYM_W-1:0] LEAF_MARK = 8'h31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_H_PAR,
      ST_H_ENT,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             error;
   } rsp_push_type;

endpackage

// File: hdl/htwd_spram.sv
`timescale 1ns / 1ps

// single-port RAM, registered read data held while idle
module htwd_spram #(
   parameter int DW    = 8,
   parameter int AW    = 4,
   parameter int DEPTH = 16
) (
   input  logic          clock,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/htwd_rsp_reg.sv
`timescale 1ns / 1ps

// result output register
module htwd_rsp_reg import htwd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  rsp_push_type     push,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [SYM_W-1:0] rsp_tdata,   // [7:0] symbol
   output logic             rsp_tlast,
   output logic [0:0]       rsp_tuser    // [0] error
);

   logic             valid_ff, valid_in;
   logic [SYM_W-1:0] sym_ff;
   logic             last_ff;
   logic             err_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         sym_ff  <= push.symbol;
         last_ff <= push.last;
         err_ff  <= push.error;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = sym_ff;
   assign rsp_tlast    = last_ff;
   assign rsp_tuser[0] = err_ff;

endmodule

// File: hdl/huffman_tree_walk_decoder.sv
// Huffman decoder: preorder header builds a node table, data bytes walk it bit-serially.
// A data byte walks 8 bit steps, plus a step per leaf, an end check and a flush; an
// empty or lone-leaf tree or an absent child ends the byte early.
// A header node with a parent adds a parent read and a parent write; a new input is
// accepted only in idle. One dependent node RAM read per bit.
// Reset (sync, active high) empties tree, stack and walk; RAMs keep stale contents.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder import htwd_pkg::*; #(
   parameter int MAX_NODES   = 512,
   parameter int STACK_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   // input stream
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] byte_value
   input  logic [1:0]       req_tuser,   // [1:0] operation
   // result stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [SYM_W-1:0] rsp_tdata,   // [7:0] symbol
   output logic             rsp_tlast,   // last_of_run
   output logic [0:0]       rsp_tuser    // [0] error
);

`include "huffman_tree_walk_decoder_assert.svh"

   // node index, node count, stack address and stack pointer widths
   localparam int NW  = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int SW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   // node entry: {right, left, leaf, symbol}
   localparam int LEAF_BIT = SYM_W;
   localparam int LEFT_LSB = SYM_W + 1;
   localparam int RGT_LSB  = SYM_W + 1 + NW;
   localparam int EW       = 2 * NW + 1 + SYM_W;

   state_type state_ff, state_in;

   logic [NCW-1:0]   node_count_ff, node_count_in;
   logic [SPW-1:0]   sp_ff, sp_in;
   logic             expect_ff, expect_in;
   logic [NW-1:0]    pos_ff, pos_in;
   logic             use_root_ff, use_root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pend_v_ff, pend_v_in;
   // payload
   logic [EW-1:0]    root_ff, root_in;
   logic [7:0]       bits_ff, bits_in;
   logic [NW-1:0]    idx_ff, idx_in;
   logic             leaf_ff, leaf_in;
   logic [NW-1:0]    par_ff, par_in;
   logic [SYM_W-1:0] pend_sym_ff, pend_sym_in;
   logic             pend_err_ff, pend_err_in;

   // node RAM port
   logic             n_en, n_we;
   logic [NW-1:0]    n_addr;
   logic [EW-1:0]    n_wdata, n_rdata;
   // stack RAM port
   logic             s_en, s_we;
   logic [SW-1:0]    s_addr;
   logic [NW-1:0]    s_wdata, s_rdata;

   rsp_push_type     push;

   logic             acc;
   logic             new_leaf;
   logic             need_attach;
   logic             hdr_alloc;
   logic             data_bad;
   logic             out_free;
   logic [EW-1:0]    cur;
   logic             arrived_leaf;
   logic [NW-1:0]    child;
   logic             child_bad;
   logic             walk_emit;
   logic             walk_stall;
   logic             left_free;
   logic [SPW-1:0]   sp_after;

   assign req_tready  = (state_ff == ST_IDLE);
   assign acc         = req_tvalid && req_tready;
   assign new_leaf    = (req_tdata == LEAF_MARK);
   assign need_attach = (node_count_ff != '0) && (sp_ff != '0);
   // an allocating header byte: no leaf symbol pending, tree not complete and table not full
   assign hdr_alloc   = !expect_ff && !((node_count_ff != '0) && (sp_ff == '0))
                        && (node_count_ff < NCW'(MAX_NODES));
   assign data_bad    = (node_count_ff == '0) || root_ff[LEAF_BIT];
   assign out_free    = !rsp_tvalid || rsp_tready;

   // walk: current node is the root after a leaf, else the fetched entry
   assign cur          = use_root_ff ? root_ff : n_rdata;
   assign arrived_leaf = !use_root_ff && n_rdata[LEAF_BIT];
   assign child        = bits_ff[7] ? cur[RGT_LSB +: NW] : cur[LEFT_LSB +: NW];
   assign child_bad    = (child == '0) || (NCW'(child) >= node_count_ff);
   assign walk_emit    = (state_ff == ST_WALK) && (arrived_leaf || ((cnt_ff != '0) && child_bad));
   assign walk_stall   = walk_emit && pend_v_ff && !out_free;

   // parent attach in ST_H_ENT
   assign left_free = (n_rdata[LEFT_LSB +: NW] == '0);
   assign sp_after  = left_free ? sp_ff : sp_ff - SPW'(1);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_tuser == OP_HEADER && hdr_alloc && need_attach) begin
                  state_in = ST_H_PAR;
               end else if (req_tuser == OP_DATA) begin
                  state_in = data_bad ? ST_DONE : ST_WALK;
               end
            end
         end
         ST_H_PAR: state_in = ST_H_ENT;
         ST_H_ENT: state_in = ST_IDLE;
         ST_WALK: begin
            if (!walk_stall && !arrived_leaf && ((cnt_ff == '0) || child_bad)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!pend_v_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath and outputs ----------------
   always_comb begin
      node_count_in = node_count_ff;
      sp_in         = sp_ff;
      expect_in     = expect_ff;
      pos_in        = pos_ff;
      use_root_in   = use_root_ff;
      cnt_in        = cnt_ff;
      pend_v_in     = pend_v_ff;
      bits_in       = bits_ff;
      idx_in        = idx_ff;
      leaf_in       = leaf_ff;
      par_in        = par_ff;
      pend_sym_in   = pend_sym_ff;
      pend_err_in   = pend_err_ff;
      n_en          = 1'b0;
      n_we          = 1'b0;
      n_addr        = pos_ff;
      n_wdata       = '0;
      s_en          = 1'b0;
      s_we          = 1'b0;
      s_addr        = '0;
      s_wdata       = idx_ff;
      push          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               unique case (req_tuser)
                  OP_CLEAR: begin
                     node_count_in = '0;
                     sp_in         = '0;
                     expect_in     = 1'b0;
                     pos_in        = '0;
                  end
                  OP_HEADER: begin
                     if (expect_ff) begin
                        // symbol of the leaf allocated last
                        n_en      = 1'b1;
                        n_we      = 1'b1;
                        n_addr    = NW'(node_count_ff - NCW'(1));
                        n_wdata   = {{(2 * NW){1'b0}}, 1'b1, req_tdata};
                        expect_in = 1'b0;
                     end else if (hdr_alloc) begin
                        n_en          = 1'b1;
                        n_we          = 1'b1;
                        n_addr        = NW'(node_count_ff);
                        n_wdata       = '0;
                        n_wdata[LEAF_BIT] = new_leaf;
                        node_count_in = node_count_ff + NCW'(1);
                        expect_in     = new_leaf;
                        idx_in        = NW'(node_count_ff);
                        leaf_in       = new_leaf;
                        if (need_attach) begin
                           s_en   = 1'b1;
                           s_addr = SW'(sp_ff - SPW'(1));
                        end else if (!new_leaf && (sp_ff < SPW'(STACK_DEPTH))) begin
                           s_en    = 1'b1;
                           s_we    = 1'b1;
                           s_addr  = SW'(sp_ff);
                           s_wdata = NW'(node_count_ff);
                           sp_in   = sp_ff + SPW'(1);
                        end
                     end
                  end
                  OP_DATA: begin
                     if (data_bad) begin
                        pend_v_in   = 1'b1;
                        pend_sym_in = '0;
                        pend_err_in = 1'b1;
                        pos_in      = '0;
                     end else begin
                        n_en        = 1'b1;
                        n_addr      = pos_ff;
                        bits_in     = req_tdata;
                        cnt_in      = CNT_W'(BYTE_BITS);
                        use_root_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_H_PAR: begin
            par_in = s_rdata;
            n_en   = 1'b1;
            n_addr = s_rdata;
         end
         ST_H_ENT: begin
            n_en    = 1'b1;
            n_we    = 1'b1;
            n_addr  = par_ff;
            n_wdata = n_rdata;
            if (left_free) begin
               n_wdata[LEFT_LSB +: NW] = idx_ff;
            end else begin
               n_wdata[RGT_LSB +: NW] = idx_ff;
            end
            sp_in = sp_after;
            if (!leaf_ff && (sp_after < SPW'(STACK_DEPTH))) begin
               s_en   = 1'b1;
               s_we   = 1'b1;
               s_addr = SW'(sp_after);
               sp_in  = sp_after + SPW'(1);
            end
         end
         ST_WALK: begin
            if (!walk_stall) begin
               if (walk_emit) begin
                  // older pending result is not the last one of this byte
                  push.valid  = pend_v_ff;
                  push.symbol = pend_sym_ff;
                  push.error  = pend_err_ff;
                  pend_v_in   = 1'b1;
                  pos_in      = '0;
                  if (arrived_leaf) begin
                     pend_sym_in = n_rdata[SYM_W-1:0];
                     pend_err_in = 1'b0;
                     use_root_in = 1'b1;
                  end else begin
                     pend_sym_in = '0;
                     pend_err_in = 1'b1;
                  end
               end else if (cnt_ff != '0) begin
                  n_en        = 1'b1;
                  n_addr      = child;
                  pos_in      = child;
                  use_root_in = 1'b0;
                  bits_in     = {bits_ff[6:0], 1'b0};
                  cnt_in      = cnt_ff - CNT_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (pend_v_ff && out_free) begin
               push.valid  = 1'b1;
               push.symbol = pend_sym_ff;
               push.last   = 1'b1;
               push.error  = pend_err_ff;
               pend_v_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // root entry kept in flops so the walk can restart without a fetch
   assign root_in = (n_en && n_we && (n_addr == '0)) ? n_wdata : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= '0;
         sp_ff         <= '0;
         expect_ff     <= 1'b0;
         pos_ff        <= '0;
         use_root_ff   <= 1'b0;
         cnt_ff        <= '0;
         pend_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         sp_ff         <= sp_in;
         expect_ff     <= expect_in;
         pos_ff        <= pos_in;
         use_root_ff   <= use_root_in;
         cnt_ff        <= cnt_in;
         pend_v_ff     <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff     <= root_in;
      bits_ff     <= bits_in;
      idx_ff      <= idx_in;
      leaf_ff     <= leaf_in;
      par_ff      <= par_in;
      pend_sym_ff <= pend_sym_in;
      pend_err_ff <= pend_err_in;
   end

   htwd_spram #(
      .DW    (EW),
      .AW    (NW),
      .DEPTH (MAX_NODES)
   ) u_node_ram (
      .clock (clock),
      .en    (n_en),
      .we    (n_we),
      .addr  (n_addr),
      .wdata (n_wdata),
      .rdata (n_rdata)
   );

   htwd_spram #(
      .DW    (NW),
      .AW    (SW),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .en    (s_en),
      .we    (s_we),
      .addr  (s_addr),
      .wdata (s_wdata),
      .rdata (s_rdata)
   );

   htwd_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `HTWD_ASSERT_NOW(a_push_free, clock, reset, push.valid, out_free, "result pushed into busy output register")
   `HTWD_ASSERT_NOW(a_count_range, clock, reset, 1'b1, node_count_ff <= NCW'(MAX_NODES), "node count beyond table")
   `HTWD_ASSERT_NOW(a_sp_range, clock, reset, 1'b1, sp_ff <= SPW'(STACK_DEPTH), "stack pointer beyond stack")
   `HTWD_ASSERT_NOW(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "error transfer with nonzero symbol")
   `HTWD_ASSERT_NEXT(a_step_fetch, clock, reset, (state_ff == ST_WALK) && !walk_stall && !walk_emit && (cnt_ff != '0), (state_ff == ST_WALK) && !use_root_ff, "bit step did not fetch child")

endmodule
